### sv/neacc_pkg.sv
// Shared types and constants for the normal-equation accumulator.
// Used by neacc_ctrl, neacc_dp and normal_equation_accumulator; no dependencies.
package neacc_pkg;

  localparam int ROW_LEN          = 6;
  localparam int ELEMENT_BITS_DEF = 32;
  localparam int FIELD_W          = 32;
  localparam int ACC_W            = 2 * FIELD_W;
  localparam int IDX_W            = 6;

  localparam int GRAM_CNT   = ROW_LEN * ROW_LEN;
  localparam int RESULT_CNT = GRAM_CNT + ROW_LEN + 1;
  localparam int GRAD_ROW   = ROW_LEN;
  localparam int RSQ_ROW    = ROW_LEN + 1;
  localparam int ROW_CNT    = ROW_LEN + 2;
  localparam int ROW_AW     = $clog2(ROW_CNT);
  localparam int LANE_W     = $clog2(ROW_LEN);

  localparam logic [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic signed [FIELD_W-1:0] jac_0;
    logic signed [FIELD_W-1:0] jac_1;
    logic signed [FIELD_W-1:0] jac_2;
    logic signed [FIELD_W-1:0] jac_3;
    logic signed [FIELD_W-1:0] jac_4;
    logic signed [FIELD_W-1:0] jac_5;
    logic signed [FIELD_W-1:0] residual;
    logic                      last_row;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]        element_index;
    logic signed [ACC_W-1:0] sum_value;
    logic                    last_of_run;
  } out_beat_t;

  typedef logic [ROW_LEN-1:0][ACC_W-1:0] acc_row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_OUT
  } state_t;

  typedef struct packed {
    logic              load;
    logic              issue;
    logic [ROW_AW-1:0] row;
    logic              emit_ld;
    logic [LANE_W-1:0] lane;
    logic [IDX_W-1:0]  idx;
    logic              out_last;
    logic              clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_row;
  } dp_status_t;

endpackage

### sv/normal_equation_accumulator.sv
// Top level of the normal-equation accumulator.
// Depends on neacc_pkg, neacc_ctrl and neacc_dp.
//
// Each input beat carries one Jacobian row of six Q16.16 values and a residual; the block
// adds J*J^T, J*r and r*r into saturating Q32.32 sums held as eight rows of six lanes in
// an on-chip memory. One row of six products is formed and written back per cycle, so an
// input beat is accepted, then makes 8 row updates and a write drain before the next is taken.
// A beat marked last_row is followed by 43 result beats, Gram entries row-major, then the
// gradient, then the residual-square sum. Each result is read from memory, loaded into the
// result register and held until out_ready; after the final result all sums read as zero.
// No input beat is taken while results are being delivered.
module normal_equation_accumulator #(
  parameter int ELEMENT_BITS = neacc_pkg::ELEMENT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  neacc_pkg::in_beat_t  in_beat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output neacc_pkg::out_beat_t out_beat
);

  neacc_pkg::ctrl_cmd_t  cmd;
  neacc_pkg::dp_status_t status;

  neacc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  neacc_dp #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_beat),
    .cmd      (cmd),
    .status   (status),
    .out_beat (out_beat)
  );

endmodule

### sv/neacc_dp.sv
// Datapath of the normal-equation accumulator: operand registers, six multipliers,
// the row-wide accumulator memory with saturating update, and the result register.
// Depends on neacc_pkg.
module neacc_dp #(
  parameter int ELEMENT_BITS = neacc_pkg::ELEMENT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  neacc_pkg::in_beat_t  in_beat,
  input  neacc_pkg::ctrl_cmd_t cmd,
  output neacc_pkg::dp_status_t status,
  output neacc_pkg::out_beat_t out_beat
);

  localparam int SHIFT = neacc_pkg::FIELD_W - ELEMENT_BITS;

  logic signed [neacc_pkg::FIELD_W-1:0] raw [neacc_pkg::ROW_LEN];
  logic signed [neacc_pkg::FIELD_W-1:0] jac_r [neacc_pkg::ROW_LEN];
  logic signed [neacc_pkg::FIELD_W-1:0] jac_nxt [neacc_pkg::ROW_LEN];
  logic signed [neacc_pkg::FIELD_W-1:0] res_r;
  logic signed [neacc_pkg::FIELD_W-1:0] res_nxt;
  logic                                 last_r;

  logic signed [neacc_pkg::FIELD_W-1:0] op_a;
  logic signed [neacc_pkg::FIELD_W-1:0] op_b [neacc_pkg::ROW_LEN];
  logic signed [neacc_pkg::ACC_W-1:0]   prod_nxt [neacc_pkg::ROW_LEN];
  logic signed [neacc_pkg::ACC_W-1:0]   prod_r [neacc_pkg::ROW_LEN];

  neacc_pkg::acc_row_t               mem_r [neacc_pkg::ROW_CNT];
  neacc_pkg::acc_row_t               rd_data_r;
  logic                              rd_vld_r;
  logic [neacc_pkg::ROW_CNT-1:0]     vld_r;
  logic                              wr_en_d1_r;
  logic [neacc_pkg::ROW_AW-1:0]      wr_row_d1_r;
  neacc_pkg::acc_row_t               sum_row;
  neacc_pkg::out_beat_t              out_r;

  function automatic logic signed [neacc_pkg::FIELD_W-1:0] widen(
    input logic [neacc_pkg::FIELD_W-1:0] x
  );
    logic signed [neacc_pkg::FIELD_W-1:0] t;
    t = $signed(x << SHIFT);
    return t >>> SHIFT;
  endfunction

  function automatic logic [neacc_pkg::ACC_W-1:0] sat_add(
    input logic [neacc_pkg::ACC_W-1:0] acc,
    input logic [neacc_pkg::ACC_W-1:0] add
  );
    logic [neacc_pkg::ACC_W-1:0] s;
    s = acc + add;
    if ((acc[neacc_pkg::ACC_W-1] == add[neacc_pkg::ACC_W-1]) &&
        (s[neacc_pkg::ACC_W-1] != acc[neacc_pkg::ACC_W-1])) begin
      s = acc[neacc_pkg::ACC_W-1] ? neacc_pkg::SAT_MIN : neacc_pkg::SAT_MAX;
    end
    return s;
  endfunction

  assign raw[0] = in_beat.jac_0;
  assign raw[1] = in_beat.jac_1;
  assign raw[2] = in_beat.jac_2;
  assign raw[3] = in_beat.jac_3;
  assign raw[4] = in_beat.jac_4;
  assign raw[5] = in_beat.jac_5;

  always_comb begin
    for (int j = 0; j < neacc_pkg::ROW_LEN; j++) begin
      jac_nxt[j] = widen(raw[j]);
    end
    res_nxt = widen(in_beat.residual);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int j = 0; j < neacc_pkg::ROW_LEN; j++) begin
        jac_r[j] <= jac_nxt[j];
      end
      res_r  <= res_nxt;
      last_r <= in_beat.last_row;
    end
  end

  // Gram rows use jac[row] * jac[j], the gradient row r * jac[j], the last row r * r.
  always_comb begin
    if (cmd.row < neacc_pkg::ROW_AW'(neacc_pkg::GRAD_ROW)) begin
      op_a = jac_r[cmd.row];
    end else begin
      op_a = res_r;
    end
    for (int j = 0; j < neacc_pkg::ROW_LEN; j++) begin
      op_b[j]     = (cmd.row == neacc_pkg::ROW_AW'(neacc_pkg::RSQ_ROW)) ? res_r : jac_r[j];
      prod_nxt[j] = op_a * op_b[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < neacc_pkg::ROW_LEN; j++) begin
      prod_r[j] <= prod_nxt[j];
    end
    rd_data_r   <= mem_r[cmd.row];
    rd_vld_r    <= vld_r[cmd.row];
    wr_row_d1_r <= cmd.row;
  end

  always_comb begin
    for (int j = 0; j < neacc_pkg::ROW_LEN; j++) begin
      sum_row[j] = sat_add(rd_vld_r ? rd_data_r[j] : '0, prod_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en_d1_r) begin
      mem_r[wr_row_d1_r] <= sum_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_en_d1_r <= 1'b0;
      vld_r      <= '0;
    end else begin
      wr_en_d1_r <= cmd.issue;
      if (cmd.clear) begin
        vld_r <= '0;
      end else if (wr_en_d1_r) begin
        vld_r[wr_row_d1_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_r.element_index <= cmd.idx;
      out_r.sum_value     <= rd_vld_r ? rd_data_r[cmd.lane] : '0;
      out_r.last_of_run   <= cmd.out_last;
    end
  end

  assign out_beat        = out_r;
  assign status.last_row = last_r;

endmodule

### sv/neacc_ctrl.sv
// Controller of the normal-equation accumulator: sequences row updates and the
// read-out of all sums. Depends on neacc_pkg.
module neacc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  neacc_pkg::dp_status_t status,
  output neacc_pkg::ctrl_cmd_t  cmd
);

  neacc_pkg::state_t                state_r, state_nxt;
  logic [neacc_pkg::ROW_AW-1:0]     row_r, row_nxt;
  logic [neacc_pkg::LANE_W-1:0]     lane_r, lane_nxt;
  logic [neacc_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic                             idx_last;

  assign idx_last = (idx_r == neacc_pkg::IDX_W'(neacc_pkg::RESULT_CNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= neacc_pkg::ST_IDLE;
      row_r   <= '0;
      lane_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      lane_r  <= lane_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    lane_nxt  = lane_r;
    idx_nxt   = idx_r;
    case (state_r)
      neacc_pkg::ST_IDLE: begin
        row_nxt = '0;
        if (in_valid) begin
          state_nxt = neacc_pkg::ST_ACC;
        end
      end
      neacc_pkg::ST_ACC: begin
        if (row_r == neacc_pkg::ROW_AW'(neacc_pkg::ROW_CNT - 1)) begin
          row_nxt   = '0;
          state_nxt = neacc_pkg::ST_DRAIN;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
      neacc_pkg::ST_DRAIN: begin
        row_nxt  = '0;
        lane_nxt = '0;
        idx_nxt  = '0;
        state_nxt = status.last_row ? neacc_pkg::ST_EMIT_RD : neacc_pkg::ST_IDLE;
      end
      neacc_pkg::ST_EMIT_RD: begin
        state_nxt = neacc_pkg::ST_EMIT_LD;
      end
      neacc_pkg::ST_EMIT_LD: begin
        state_nxt = neacc_pkg::ST_EMIT_OUT;
      end
      neacc_pkg::ST_EMIT_OUT: begin
        if (out_ready) begin
          if (idx_last) begin
            state_nxt = neacc_pkg::ST_IDLE;
          end else begin
            state_nxt = neacc_pkg::ST_EMIT_RD;
            idx_nxt   = idx_r + 1'b1;
            if (lane_r == neacc_pkg::LANE_W'(neacc_pkg::ROW_LEN - 1)) begin
              lane_nxt = '0;
              row_nxt  = row_r + 1'b1;
            end else begin
              lane_nxt = lane_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = neacc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd          = '0;
    cmd.row      = row_r;
    cmd.lane     = lane_r;
    cmd.idx      = idx_r;
    cmd.out_last = idx_last;
    case (state_r)
      neacc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      neacc_pkg::ST_ACC: begin
        cmd.issue = 1'b1;
      end
      neacc_pkg::ST_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
      end
      neacc_pkg::ST_EMIT_OUT: begin
        out_valid = 1'b1;
        cmd.clear = out_ready && idx_last;
      end
      default: begin
      end
    endcase
  end

  a_accept_starts_row0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == neacc_pkg::ST_ACC && row_r == '0))
    else $error("accepted beat did not start the row sweep at row zero");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_final_index_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == neacc_pkg::ST_EMIT_OUT && idx_last) |->
      (row_r == neacc_pkg::ROW_AW'(neacc_pkg::RSQ_ROW) && lane_r == '0))
    else $error("final result not taken from the residual-square row");

  a_sweep_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == neacc_pkg::ST_ACC &&
     row_r == neacc_pkg::ROW_AW'(neacc_pkg::ROW_CNT - 1)) |=>
      (state_r == neacc_pkg::ST_DRAIN))
    else $error("row sweep did not end in the drain cycle");

endmodule
